// File: sv/pip_pkg.sv
// pip_pkg: shared constants for the even-odd point-in-polygon block
// no dependencies
`timescale 1ns / 1ps

package pip_pkg;

  localparam int unsigned CoordWidthDef = 32;
  localparam int unsigned CoordWidthMin = 8;
  localparam int unsigned CoordWidthMax = 32;

endpackage

// File: sv/point_in_polygon_even_odd.sv
// Even-odd point-in-polygon test. One polygon edge is taken per cycle with the
// query point while no result is stalled; a polygon's result passes the
// translation, cross-product and output registers, then waits in the output
// register until transferred. The translation and the cross-product multipliers
// are each followed by a register. Coordinates are the low COORD_WIDTH bits of
// each field, sign-extended. A query point on a vertex always reads as inside.
// Parity and vertex state clear after each last edge. Depends on pip_pkg and
// pip_cross.
`timescale 1ns / 1ps

module point_in_polygon_even_odd
  import pip_pkg::*;
#(
  parameter int unsigned COORD_WIDTH = CoordWidthDef
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic signed [COORD_WIDTH-1:0] edge_start_x_i,
  input  logic signed [COORD_WIDTH-1:0] edge_start_y_i,
  input  logic signed [COORD_WIDTH-1:0] edge_end_x_i,
  input  logic signed [COORD_WIDTH-1:0] edge_end_y_i,
  input  logic signed [COORD_WIDTH-1:0] query_x_i,
  input  logic signed [COORD_WIDTH-1:0] query_y_i,
  input  logic                          last_edge_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic                          inside_res_o
);

  localparam int unsigned TW = COORD_WIDTH + 1;
  localparam int unsigned OW = COORD_WIDTH + 2;

  logic advance;

  // stage a: translated coordinates
  logic signed [TW-1:0] x0_d, y0_d, x1_d, y1_d;
  logic signed [TW-1:0] x0_q, y0_q, x1_q, y1_q;
  logic                 a_vld_q, a_last_q, a_hit_q, a_hit_d;

  // stage b: products inside pip_cross
  logic                 b_vld_q, b_last_q, b_hit_q;
  logic                 cross_e, cross_o_off;
  logic signed [OW-1:0] ox0, oy0, ox1, oy1;

  // polygon state and result
  logic pe_q, pe_d, po_q, po_d, vh_q, vh_d;
  logic out_vld_q, out_vld_d, inside_q, inside_d;

  assign advance    = !out_vld_q || out_ready_i;
  assign in_ready_o = advance;

  assign x0_d = $signed({edge_start_x_i[COORD_WIDTH-1], edge_start_x_i})
              - $signed({query_x_i[COORD_WIDTH-1], query_x_i});
  assign y0_d = $signed({edge_start_y_i[COORD_WIDTH-1], edge_start_y_i})
              - $signed({query_y_i[COORD_WIDTH-1], query_y_i});
  assign x1_d = $signed({edge_end_x_i[COORD_WIDTH-1], edge_end_x_i})
              - $signed({query_x_i[COORD_WIDTH-1], query_x_i});
  assign y1_d = $signed({edge_end_y_i[COORD_WIDTH-1], edge_end_y_i})
              - $signed({query_y_i[COORD_WIDTH-1], query_y_i});
  assign a_hit_d = ((x0_d == '0) && (y0_d == '0)) || ((x1_d == '0) && (y1_d == '0));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_vld_q <= 1'b0;
      b_vld_q <= 1'b0;
    end else if (advance) begin
      a_vld_q <= in_valid_i;
      b_vld_q <= a_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      x0_q     <= x0_d;
      y0_q     <= y0_d;
      x1_q     <= x1_d;
      y1_q     <= y1_d;
      a_last_q <= last_edge_i;
      a_hit_q  <= a_hit_d;
      b_last_q <= a_last_q;
      b_hit_q  <= a_hit_q;
    end
  end

  // half-open variant: every coordinate lowered by one
  assign ox0 = $signed({x0_q[TW-1], x0_q}) - $signed({{(OW-1){1'b0}}, 1'b1});
  assign oy0 = $signed({y0_q[TW-1], y0_q}) - $signed({{(OW-1){1'b0}}, 1'b1});
  assign ox1 = $signed({x1_q[TW-1], x1_q}) - $signed({{(OW-1){1'b0}}, 1'b1});
  assign oy1 = $signed({y1_q[TW-1], y1_q}) - $signed({{(OW-1){1'b0}}, 1'b1});

  pip_cross #(
    .W(TW)
  ) u_cross_exact (
    .clk_i  (clk_i),
    .en_i   (advance),
    .x0_i   (x0_q),
    .y0_i   (y0_q),
    .x1_i   (x1_q),
    .y1_i   (y1_q),
    .cross_o(cross_e)
  );

  pip_cross #(
    .W(OW)
  ) u_cross_offset (
    .clk_i  (clk_i),
    .en_i   (advance),
    .x0_i   (ox0),
    .y0_i   (oy0),
    .x1_i   (ox1),
    .y1_i   (oy1),
    .cross_o(cross_o_off)
  );

  always_comb begin
    pe_d      = pe_q;
    po_d      = po_q;
    vh_d      = vh_q;
    out_vld_d = out_vld_q;
    inside_d  = inside_q;
    if (advance) begin
      out_vld_d = 1'b0;
      if (b_vld_q) begin
        pe_d = pe_q ^ cross_e;
        po_d = po_q ^ cross_o_off;
        vh_d = vh_q | b_hit_q;
        if (b_last_q) begin
          out_vld_d = 1'b1;
          inside_d  = vh_d | pe_d | po_d;
          pe_d      = 1'b0;
          po_d      = 1'b0;
          vh_d      = 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pe_q      <= 1'b0;
      po_q      <= 1'b0;
      vh_q      <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      pe_q      <= pe_d;
      po_q      <= po_d;
      vh_q      <= vh_d;
      out_vld_q <= out_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    inside_q <= inside_d;
  end

  assign out_valid_o  = out_vld_q;
  assign inside_res_o = inside_q;

endmodule

// File: sv/pip_cross.sv
// pip_cross: crossing test of one translated edge against the origin
// registers the two cross products and sign flags; depends on pip_pkg
`timescale 1ns / 1ps

module pip_cross
  import pip_pkg::*;
#(
  parameter int unsigned W = CoordWidthDef + 1
) (
  input  logic                clk_i,
  input  logic                en_i,
  input  logic signed [W-1:0] x0_i,
  input  logic signed [W-1:0] y0_i,
  input  logic signed [W-1:0] x1_i,
  input  logic signed [W-1:0] y1_i,
  output logic                cross_o
);

  logic signed [2*W-1:0] prod_a_d, prod_a_q;
  logic signed [2*W-1:0] prod_b_d, prod_b_q;
  logic                  straddle_d, straddle_q;
  logic                  xsame_d, xsame_q;
  logic                  x0neg_q, y1neg_q;
  logic [2*W:0]          diff;

  // zero counts as positive
  assign straddle_d = (y0_i[W-1] != y1_i[W-1]);
  assign xsame_d    = (x0_i[W-1] == x1_i[W-1]);
  assign prod_a_d   = x0_i * y1_i;
  assign prod_b_d   = x1_i * y0_i;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      prod_a_q   <= prod_a_d;
      prod_b_q   <= prod_b_d;
      straddle_q <= straddle_d;
      xsame_q    <= xsame_d;
      x0neg_q    <= x0_i[W-1];
      y1neg_q    <= y1_i[W-1];
    end
  end

  assign diff = {prod_a_q[2*W-1], prod_a_q} - {prod_b_q[2*W-1], prod_b_q};

  always_comb begin
    if (!straddle_q) begin
      cross_o = 1'b0;
    end else if (xsame_q) begin
      cross_o = x0neg_q;
    end else begin
      cross_o = (diff[2*W] != y1neg_q);
    end
  end

endmodule

// File: sv/pip_checker.sv
// pip_port_chk: port-level checks on point_in_polygon_even_odd
// bound to the top level; no package dependency
`timescale 1ns / 1ps

module pip_port_chk (
  input logic clk_i,
  input logic rst_ni,
  input logic in_valid_i,
  input logic in_ready_i,
  input logic out_valid_i,
  input logic out_ready_i,
  input logic inside_res_i
);

  // held result stays put until its transfer
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(inside_res_i))
    else $error("result dropped or changed while stalled");

  // input side only blocks while a result waits
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_ready_i == (!out_valid_i || out_ready_i))
    else $error("input ready does not follow output stall");

  // a new result only appears right after the pipe moved
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_i) |-> $past(in_ready_i))
    else $error("result appeared while pipeline was stalled");

  // no input transfer while a result is stalled
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |-> !(in_valid_i && in_ready_i))
    else $error("input transfer during output stall");

endmodule

bind point_in_polygon_even_odd pip_port_chk u_pip_port_chk (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_ready_i  (in_ready_o),
  .out_valid_i (out_valid_o),
  .out_ready_i (out_ready_i),
  .inside_res_i(inside_res_o)
);
